// ----- hw/rtl/rgb2hsv_pkg.sv -----
// rgb2hsv_pkg: shared constants and the per-pixel flag group for the
// rgb to hsv converter; no dependencies

package rgb2hsv_pkg;

  // default channel width of the pixel stream
  localparam int CHANNEL_BITS_DEFAULT = 8;

  // hue and saturation are both 16-bit quotients
  localparam int QUOT_BITS = 16;

  // restoring divider: steps done per pipeline stage, and stage count
  localparam int DIV_STEPS_PER_STAGE = 4;
  localparam int DIV_STAGES          = QUOT_BITS / DIV_STEPS_PER_STAGE;

  localparam logic [QUOT_BITS-1:0] HUE_MAX = '1;

  // special cases found up front and carried down the divider stages
  typedef struct packed {
    logic hue_zero;   // chroma is zero, grey pixel
    logic hue_full;   // hue fraction is a full turn, saturate
    logic sat_zero;   // largest channel is zero, black pixel
  } hsv_flags_t;

endpackage

// ----- hw/rtl/rgb2hsv_front.sv -----
// rgb2hsv_front: sector swaps, chroma and hue numerator, divider setup
// depends on rgb2hsv_pkg

module rgb2hsv_front
  import rgb2hsv_pkg::*;
#(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEFAULT
) (
  input  logic                    clk,
  input  logic                    load,
  input  logic [CHANNEL_BITS-1:0] red,
  input  logic [CHANNEL_BITS-1:0] green,
  input  logic [CHANNEL_BITS-1:0] blue,
  output logic [CHANNEL_BITS-1:0] value,
  output logic [CHANNEL_BITS+2:0] hue_div,
  output logic [CHANNEL_BITS+2:0] hue_rem,
  output logic [CHANNEL_BITS-1:0] sat_rem,
  output logic [QUOT_BITS-1:0]    sat_acc,
  output hsv_flags_t              flags
);

  localparam int CB = CHANNEL_BITS;
  localparam int DW = CB + 3;
  localparam int NW = CB + 4;

  // which swaps happened: {green/blue swap, red/green swap}
  localparam logic [1:0] SECT_NONE = 2'b00;
  localparam logic [1:0] SECT_RG   = 2'b01;
  localparam logic [1:0] SECT_GB   = 2'b10;
  localparam logic [1:0] SECT_BOTH = 2'b11;

  logic                 swap_gb;
  logic                 swap_rg;
  logic [CB-1:0]        g1;
  logic [CB-1:0]        b1;
  logic [CB-1:0]        r2;
  logic [CB-1:0]        g2;
  logic [CB-1:0]        lo;
  logic [CB-1:0]        chroma;
  logic [DW-1:0]        c_x2;
  logic [DW-1:0]        c_x4;
  logic [DW-1:0]        c_x6;
  logic signed [NW-1:0] k6c;
  logic signed [NW-1:0] num;
  logic [NW-1:0]        mag;

  always_comb begin
    swap_gb = green < blue;
    g1      = swap_gb ? blue : green;
    b1      = swap_gb ? green : blue;
    swap_rg = red < g1;
    r2      = swap_rg ? g1 : red;
    g2      = swap_rg ? red : g1;
    lo      = (g2 < b1) ? g2 : b1;
    chroma  = r2 - lo;
    c_x2    = {2'b00, chroma, 1'b0};
    c_x4    = {1'b0, chroma, 2'b00};
    c_x6    = c_x2 + c_x4;
    // sector offset times chroma: 0, -6c, -2c or 4c
    case ({swap_gb, swap_rg})
      SECT_NONE: k6c = '0;
      SECT_GB:   k6c = -signed'({1'b0, c_x6});
      SECT_RG:   k6c = -signed'({1'b0, c_x2});
      SECT_BOTH: k6c = signed'({1'b0, c_x4});
      default:   k6c = '0;
    endcase
    num = k6c + signed'(NW'(g2)) - signed'(NW'(b1));
    mag = num[NW-1] ? unsigned'(-num) : unsigned'(num);
  end

  // saturation dividend 65535*c split as (c-1) on top and (65536-c) below
  always_ff @(posedge clk) begin
    if (load) begin
      value          <= r2;
      hue_div        <= c_x6;
      hue_rem        <= mag[DW-1:0];
      sat_rem        <= (chroma == '0) ? '0 : chroma - CB'(1);
      sat_acc        <= '0 - QUOT_BITS'(chroma);
      flags.hue_zero <= (chroma == '0);
      flags.hue_full <= (chroma != '0) && (mag[DW-1:0] == c_x6);
      flags.sat_zero <= (r2 == '0);
    end
  end

endmodule

// ----- hw/rtl/rgb2hsv_div_stage.sv -----
// rgb2hsv_div_stage: a few restoring-division steps for hue and saturation
// depends on rgb2hsv_pkg

module rgb2hsv_div_stage
  import rgb2hsv_pkg::*;
#(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEFAULT,
  parameter int STEPS        = DIV_STEPS_PER_STAGE
) (
  input  logic                    clk,
  input  logic                    load,
  input  logic [CHANNEL_BITS-1:0] value_i,
  input  logic [CHANNEL_BITS+2:0] hue_div_i,
  input  logic [CHANNEL_BITS+2:0] hue_rem_i,
  input  logic [QUOT_BITS-1:0]    hue_quo_i,
  input  logic [CHANNEL_BITS-1:0] sat_rem_i,
  input  logic [QUOT_BITS-1:0]    sat_acc_i,
  input  hsv_flags_t              flags_i,
  output logic [CHANNEL_BITS-1:0] value_o,
  output logic [CHANNEL_BITS+2:0] hue_div_o,
  output logic [CHANNEL_BITS+2:0] hue_rem_o,
  output logic [QUOT_BITS-1:0]    hue_quo_o,
  output logic [CHANNEL_BITS-1:0] sat_rem_o,
  output logic [QUOT_BITS-1:0]    sat_acc_o,
  output hsv_flags_t              flags_o
);

  localparam int CB = CHANNEL_BITS;
  localparam int DW = CB + 3;
  localparam int QB = QUOT_BITS;

  logic [DW-1:0] hr;
  logic [DW:0]   ht;
  logic [QB-1:0] hq;
  logic [CB-1:0] sr;
  logic [CB:0]   st;
  logic [QB-1:0] sa;

  // hue shifts in zeros; saturation pulls dividend bits from the top of
  // sat_acc while quotient bits fill in from the bottom
  always_comb begin
    hr = hue_rem_i;
    hq = hue_quo_i;
    sr = sat_rem_i;
    sa = sat_acc_i;
    ht = '0;
    st = '0;
    for (int i = 0; i < STEPS; i++) begin
      ht = {hr, 1'b0};
      if (ht >= {1'b0, hue_div_i}) begin
        hr = DW'(ht - {1'b0, hue_div_i});
        hq = {hq[QB-2:0], 1'b1};
      end else begin
        hr = ht[DW-1:0];
        hq = {hq[QB-2:0], 1'b0};
      end
      st = {sr, sa[QB-1]};
      if (st >= {1'b0, value_i}) begin
        sr = CB'(st - {1'b0, value_i});
        sa = {sa[QB-2:0], 1'b1};
      end else begin
        sr = st[CB-1:0];
        sa = {sa[QB-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      value_o   <= value_i;
      hue_div_o <= hue_div_i;
      hue_rem_o <= hr;
      hue_quo_o <= hq;
      sat_rem_o <= sr;
      sat_acc_o <= sa;
      flags_o   <= flags_i;
    end
  end

endmodule

// ----- hw/rtl/rgb_to_hsv_converter_unit.sv -----
// rgb_to_hsv_converter_unit: pipelined rgb to hsv pixel converter, top level
// depends on rgb2hsv_pkg, rgb2hsv_front, rgb2hsv_div_stage
//
//   channel | signals                          | transfer when
//   --------+----------------------------------+-----------------------------
//   pixel   | pixel_valid, pixel_stall,        | pixel_valid && !pixel_stall
//           | red, green, blue                 |
//   hsv     | hsv_valid, hsv_stall,            | hsv_valid && !hsv_stall
//           | hue, saturation, value           |
//
// one pixel per cycle sustained while hsv_stall is low; the pipeline runs
// front stage, one stage per DIV_STEPS_PER_STAGE quotient bits, then the
// output register
// the length of the pipeline is set by the two 16-bit restoring dividers
// rst clears only the valid bits; data registers load on transfer
// each stage accepts when empty or when the stage below moves, so bubbles
// close up and a stalled hsv output holds while earlier stages keep filling

module rgb_to_hsv_converter_unit
  import rgb2hsv_pkg::*;
#(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    pixel_valid,
  output logic                    pixel_stall,
  input  logic [CHANNEL_BITS-1:0] red,
  input  logic [CHANNEL_BITS-1:0] green,
  input  logic [CHANNEL_BITS-1:0] blue,
  output logic                    hsv_valid,
  input  logic                    hsv_stall,
  output logic [QUOT_BITS-1:0]    hue,
  output logic [QUOT_BITS-1:0]    saturation,
  output logic [CHANNEL_BITS-1:0] value
);

  localparam int CB = CHANNEL_BITS;
  localparam int DW = CB + 3;
  localparam int DS = DIV_STAGES;

  // stage 0 is the front end, stages 1..DS the divider
  logic [DS:0]   vld;
  logic [DS+1:0] rdy;

  logic [CB-1:0]        val_p     [DS+1];
  logic [DW-1:0]        hue_div_p [DS+1];
  logic [DW-1:0]        hue_rem_p [DS+1];
  logic [QUOT_BITS-1:0] hue_quo_p [DS+1];
  logic [CB-1:0]        sat_rem_p [DS+1];
  logic [QUOT_BITS-1:0] sat_acc_p [DS+1];
  hsv_flags_t           flg_p     [DS+1];

  // ready chain, output register at the bottom
  assign rdy[DS+1] = !hsv_valid || !hsv_stall;
  for (genvar k = 0; k <= DS; k++) begin : g_rdy
    assign rdy[k] = !vld[k] || rdy[k+1];
  end
  assign pixel_stall = !rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      hsv_valid <= 1'b0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= pixel_valid;
      end
      for (int k = 1; k <= DS; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
      if (rdy[DS+1]) begin
        hsv_valid <= vld[DS];
      end
    end
  end

  // sector, chroma and divider operands
  rgb2hsv_front #(
    .CHANNEL_BITS(CB)
  ) u_front (
    .clk     (clk),
    .load    (rdy[0] && pixel_valid),
    .red     (red),
    .green   (green),
    .blue    (blue),
    .value   (val_p[0]),
    .hue_div (hue_div_p[0]),
    .hue_rem (hue_rem_p[0]),
    .sat_rem (sat_rem_p[0]),
    .sat_acc (sat_acc_p[0]),
    .flags   (flg_p[0])
  );
  assign hue_quo_p[0] = '0;

  // both quotients built a few bits per stage
  for (genvar k = 1; k <= DS; k++) begin : g_div
    rgb2hsv_div_stage #(
      .CHANNEL_BITS(CB),
      .STEPS       (DIV_STEPS_PER_STAGE)
    ) u_div (
      .clk       (clk),
      .load      (rdy[k] && vld[k-1]),
      .value_i   (val_p[k-1]),
      .hue_div_i (hue_div_p[k-1]),
      .hue_rem_i (hue_rem_p[k-1]),
      .hue_quo_i (hue_quo_p[k-1]),
      .sat_rem_i (sat_rem_p[k-1]),
      .sat_acc_i (sat_acc_p[k-1]),
      .flags_i   (flg_p[k-1]),
      .value_o   (val_p[k]),
      .hue_div_o (hue_div_p[k]),
      .hue_rem_o (hue_rem_p[k]),
      .hue_quo_o (hue_quo_p[k]),
      .sat_rem_o (sat_rem_p[k]),
      .sat_acc_o (sat_acc_p[k]),
      .flags_o   (flg_p[k])
    );
  end

  // output register: grey, full-turn and black pixels override the quotients
  always_ff @(posedge clk) begin
    if (rdy[DS+1] && vld[DS]) begin
      if (flg_p[DS].hue_zero) begin
        hue <= '0;
      end else if (flg_p[DS].hue_full) begin
        hue <= HUE_MAX;
      end else begin
        hue <= hue_quo_p[DS];
      end
      saturation <= flg_p[DS].sat_zero ? '0 : sat_acc_p[DS];
      value      <= val_p[DS];
    end
  end

  // a black pixel has neither hue nor saturation
  a_black_zero: assert property (@(posedge clk) disable iff (rst)
    hsv_valid && (value == '0) |-> (saturation == '0) && (hue == '0))
    else $error("black pixel with nonzero hue or saturation");

  // zero saturation means zero chroma, hence zero hue
  a_grey_hue: assert property (@(posedge clk) disable iff (rst)
    hsv_valid && (saturation == '0) |-> (hue == '0))
    else $error("grey pixel with nonzero hue");

  // a full turn needs nonzero chroma
  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    vld[0] |-> $onehot0({flg_p[0].hue_zero, flg_p[0].hue_full}))
    else $error("hue flagged both zero and full");

  // zero max channel implies zero chroma
  a_black_grey: assert property (@(posedge clk) disable iff (rst)
    vld[0] && flg_p[0].sat_zero |-> flg_p[0].hue_zero)
    else $error("black pixel without grey flag");

  // an accepted pixel lands in the front stage
  a_front_fill: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && !pixel_stall |=> vld[0])
    else $error("accepted pixel lost at front stage");

endmodule
